// ===== rtl/vtpd_pkg.sv =====
// Shared types and constants of the vertex transform and perspective divide pipeline.
package vtpd_pkg;

    localparam int NUM_REGS        = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int COORD_W         = 32;
    localparam int PROD_W          = 2 * COORD_W;
    localparam int FRAC_W          = 16;
    localparam int SUM_W           = PROD_W + 2 - FRAC_W;
    localparam int QUO_W           = 32;
    localparam int STEPS_PER_STAGE = 2;

    localparam logic [63:0] REG_RESET [NUM_REGS] = '{
        64'h0000_0000_0001_0000, 64'h0,
        64'h0001_0000_0000_0000, 64'h0,
        64'h0,                   64'h0000_0000_0001_0000,
        64'h0,                   64'h0001_0000_0000_0000
    };

    localparam logic [QUO_W:0] POS_LIMIT = 33'h0_7FFF_FFFF;
    localparam logic [QUO_W:0] NEG_LIMIT = 33'h0_8000_0000;

    // One divider lane: partial remainder, divisor, quotient, dividend bits left, overflow and sign flags
    typedef struct packed {
        logic [SUM_W:0]   rem;
        logic [SUM_W-1:0] den;
        logic [QUO_W-1:0] quo;
        logic [QUO_W-1:0] nbits;
        logic             ovf;
        logic             neg;
    } t_lane;

    typedef struct packed {
        t_lane [2:0]               lane;
        logic                      divide;
        logic [2:0][COORD_W-1:0]   clamp;
        logic                      clamp_sat;
    } t_item;

endpackage

// ===== rtl/vertex_transform_perspective_divide.sv =====
// Top level: 4x4 Q16.16 vertex transform with saturating perspective divide.
// Pipeline: the 3-stage multiply/sum front, one setup stage, the divider stages
// and the output register.
// Throughput: one word per cycle; the whole pipeline holds while the output waits.
// Reset (synchronous, active low) clears all valid bits and loads the identity matrix.
// Configuration writes are always ready and are registered on the edge that accepts them.
module vertex_transform_perspective_divide #(
    parameter int STEPS_PER_STAGE = vtpd_pkg::STEPS_PER_STAGE
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [vtpd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                    i_cfg_data,
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [127:0]                   s_axis_tdata,  // in_x, in_y, in_z, in_w
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [95:0]                    m_axis_tdata,  // out_x, out_y, out_z
    output logic [1:0]                     m_axis_tuser   // divided, saturated
);
    localparam int SW     = vtpd_pkg::SUM_W;
    localparam int QW     = vtpd_pkg::QUO_W;
    localparam int CW     = vtpd_pkg::COORD_W;
    localparam int NSTAGE = QW / STEPS_PER_STAGE;

    // Matrix registers
    logic [63:0] r_coef [vtpd_pkg::NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= vtpd_pkg::REG_RESET;
        end else if (i_cfg_valid) begin
            r_coef[i_cfg_index] <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // Global advance: move every stage whenever the output register can take a word
    logic ce;
    assign ce            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = ce;

    logic                 sum_valid;
    logic signed [SW-1:0] sum [4];

    vtpd_rowsum u_rowsum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (s_axis_tvalid),
        .i_vec   (s_axis_tdata),
        .i_coef  (r_coef),
        .o_valid (sum_valid),
        .o_sum   (sum)
    );

    // Divider setup: magnitudes, overflow test, undivided clamp
    vtpd_pkg::t_item n_setup;
    vtpd_pkg::t_item r_setup;
    logic            r_setup_valid;
    logic [SW-1:0]   den_mag;
    logic [SW-1:0]   num_mag [3];

    always_comb begin
        den_mag = sum[3][SW-1] ? SW'(-sum[3]) : SW'(sum[3]);
        n_setup = '0;
        n_setup.divide = (sum[3] != '0);
        for (int l = 0; l < 3; l++) begin
            num_mag[l] = sum[l][SW-1] ? SW'(-sum[l]) : SW'(sum[l]);
            n_setup.lane[l].den   = den_mag;
            n_setup.lane[l].neg   = sum[l][SW-1] ^ sum[3][SW-1];
            // quotient reaches 2^16 when the integer part of n/2^16 is at least d
            n_setup.lane[l].ovf   = ({{vtpd_pkg::FRAC_W{1'b0}},
                                      num_mag[l][SW-1:vtpd_pkg::FRAC_W]} >= den_mag);
            n_setup.lane[l].rem   = (SW + 1)'(num_mag[l][SW-1:vtpd_pkg::FRAC_W]);
            n_setup.lane[l].nbits = {num_mag[l][vtpd_pkg::FRAC_W-1:0],
                                     {(QW - vtpd_pkg::FRAC_W){1'b0}}};
            n_setup.lane[l].quo   = '0;
            if (sum[l][SW-1:CW-1] == '0 || sum[l][SW-1:CW-1] == '1) begin
                n_setup.clamp[l] = sum[l][CW-1:0];
            end else begin
                n_setup.clamp[l] = sum[l][SW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                n_setup.clamp_sat = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setup_valid <= 1'b0;
        end else if (ce) begin
            r_setup_valid <= sum_valid;
        end
        if (ce) begin
            r_setup <= n_setup;
        end
    end

    // Divider pipeline
    vtpd_pkg::t_item div_item  [NSTAGE+1];
    logic            div_valid [NSTAGE+1];

    assign div_item[0]  = r_setup;
    assign div_valid[0] = r_setup_valid;

    for (genvar g = 0; g < NSTAGE; g++) begin : g_div
        vtpd_div_stage #(.STEPS(STEPS_PER_STAGE)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (ce),
            .i_valid (div_valid[g]),
            .i_item  (div_item[g]),
            .o_valid (div_valid[g+1]),
            .o_item  (div_item[g+1])
        );
    end

    // Output: apply sign and saturate quotients, or pass the clamped sums
    vtpd_pkg::t_item     fin;
    logic [2:0][CW-1:0]  n_data;
    logic                n_sat;
    logic [QW:0]         quo_ext;
    logic [95:0]         r_data;
    logic [1:0]          r_user;
    logic                r_out_valid;

    assign fin = div_item[NSTAGE];

    always_comb begin
        n_sat   = 1'b0;
        n_data  = fin.clamp;
        quo_ext = '0;
        if (fin.divide) begin
            for (int l = 0; l < 3; l++) begin
                quo_ext = {1'b0, fin.lane[l].quo};
                if (fin.lane[l].neg) begin
                    if (fin.lane[l].ovf || quo_ext > vtpd_pkg::NEG_LIMIT) begin
                        n_sat     = 1'b1;
                        n_data[l] = 32'h8000_0000;
                    end else begin
                        n_data[l] = CW'(-quo_ext);
                    end
                end else begin
                    if (fin.lane[l].ovf || quo_ext > vtpd_pkg::POS_LIMIT) begin
                        n_sat     = 1'b1;
                        n_data[l] = 32'h7FFF_FFFF;
                    end else begin
                        n_data[l] = quo_ext[CW-1:0];
                    end
                end
            end
        end else begin
            n_sat = fin.clamp_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ce) begin
            r_out_valid <= div_valid[NSTAGE];
        end
        if (ce) begin
            r_data <= n_data;
            r_user <= {n_sat, fin.divide};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_data;
    assign m_axis_tuser  = r_user;

    // A saturated word holds a bound in at least one lane
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            m_axis_tdata[31:0]  == 32'h7FFF_FFFF || m_axis_tdata[31:0]  == 32'h8000_0000 ||
            m_axis_tdata[63:32] == 32'h7FFF_FFFF || m_axis_tdata[63:32] == 32'h8000_0000 ||
            m_axis_tdata[95:64] == 32'h7FFF_FFFF || m_axis_tdata[95:64] == 32'h8000_0000)
        else $error("saturated flag without a clamped lane");

    // A stalled result holds while the pipeline is frozen
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed during stall");

    // Input ready follows the output side alone
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready disagrees with pipeline advance");

    // Reset leaves no result pending
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");
endmodule

// ===== rtl/vtpd_rowsum.sv =====
// Matrix-vector multiply and rounded row sums, three register stages.
module vtpd_rowsum (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_ce,
    input  logic                                   i_valid,
    input  logic [3:0][vtpd_pkg::COORD_W-1:0]      i_vec,
    input  logic [63:0]                            i_coef [vtpd_pkg::NUM_REGS],
    output logic                                   o_valid,
    output logic signed [vtpd_pkg::SUM_W-1:0]      o_sum [4]
);
    localparam int PW = vtpd_pkg::PROD_W;

    logic signed [PW-1:0]   r_prod [4][4];
    logic signed [PW:0]     r_pair [4][2];
    logic signed [vtpd_pkg::SUM_W-1:0] r_sum [4];
    logic [2:0]             r_valid;

    logic signed [PW-1:0]   n_prod [4][4];
    logic signed [PW:0]     n_pair [4][2];
    logic signed [vtpd_pkg::SUM_W-1:0] n_sum [4];
    logic [PW+1:0]          t_full [4];

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                n_prod[r][c] = $signed((c % 2 == 1) ? i_coef[r * 2 + c / 2][63:32]
                                                    : i_coef[r * 2 + c / 2][31:0])
                             * $signed(i_vec[c]);
            end
            n_pair[r][0] = (PW + 1)'(r_prod[r][0]) + (PW + 1)'(r_prod[r][1]);
            n_pair[r][1] = (PW + 1)'(r_prod[r][2]) + (PW + 1)'(r_prod[r][3]);
            // round half up, then floor by the fraction width
            t_full[r] = (PW + 2)'(r_pair[r][0]) + (PW + 2)'(r_pair[r][1])
                      + (PW + 2)'(1 << (vtpd_pkg::FRAC_W - 1));
            n_sum[r]  = $signed(t_full[r][PW+1:vtpd_pkg::FRAC_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ce) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
        if (i_ce) begin
            r_prod <= n_prod;
            r_pair <= n_pair;
            r_sum  <= n_sum;
        end
    end

    assign o_valid = r_valid[2];
    assign o_sum   = r_sum;
endmodule

// ===== rtl/vtpd_div_stage.sv =====
// One pipeline stage of the restoring divider, STEPS quotient bits per lane.
module vtpd_div_stage #(
    parameter int STEPS = vtpd_pkg::STEPS_PER_STAGE
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_ce,
    input  logic                i_valid,
    input  vtpd_pkg::t_item     i_item,
    output logic                o_valid,
    output vtpd_pkg::t_item     o_item
);
    localparam int SW = vtpd_pkg::SUM_W;
    localparam int QW = vtpd_pkg::QUO_W;

    vtpd_pkg::t_item r_item, n_item;
    logic            r_valid;
    logic [SW:0]     t_rem;

    always_comb begin
        n_item = i_item;
        t_rem  = '0;
        for (int l = 0; l < 3; l++) begin
            for (int s = 0; s < STEPS; s++) begin
                t_rem = {n_item.lane[l].rem[SW-1:0], n_item.lane[l].nbits[QW-1]};
                n_item.lane[l].nbits = {n_item.lane[l].nbits[QW-2:0], 1'b0};
                if (t_rem >= {1'b0, n_item.lane[l].den}) begin
                    n_item.lane[l].rem = t_rem - {1'b0, n_item.lane[l].den};
                    n_item.lane[l].quo = {n_item.lane[l].quo[QW-2:0], 1'b1};
                end else begin
                    n_item.lane[l].rem = t_rem;
                    n_item.lane[l].quo = {n_item.lane[l].quo[QW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ce) begin
            r_valid <= i_valid;
        end
        if (i_ce) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

// ===== tb/vertex_transform_perspective_divide_tb.sv =====
// Self-checking testbench for the 4x4 vertex transform with perspective divide.
`timescale 1ns / 1ps

module vertex_transform_perspective_divide_tb;

    localparam int PIPE_LATENCY = 5 + 32 / vtpd_pkg::STEPS_PER_STAGE;
    localparam logic signed [79:0] INT32_HI = 80'sd2147483647;
    localparam logic signed [79:0] INT32_LO = -80'sd2147483648;
    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    // register indexes of the coefficient matrix
    typedef enum logic [vtpd_pkg::CFG_IDX_W-1:0] {
        ROW0_COLS01, ROW0_COLS23, ROW1_COLS01, ROW1_COLS23,
        ROW2_COLS01, ROW2_COLS23, ROW3_COLS01, ROW3_COLS23
    } t_reg_idx;

    // flavors of coefficient sets loaded between phases
    typedef enum int { MAT_FULL, MAT_PERSPECTIVE, MAT_MAX, MAT_MIN } t_mat_kind;

    typedef struct {
        logic [31:0] x, y, z;
        logic        divided;
        logic        saturated;
    } t_vertex_out;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_cfg_valid;
    logic           o_cfg_ready;
    logic [2:0]     i_cfg_index;
    logic [63:0]    i_cfg_data;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [127:0]   s_axis_tdata;   // in_x, in_y, in_z, in_w
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    logic [95:0]    m_axis_tdata;   // out_x, out_y, out_z
    logic [1:0]     m_axis_tuser;   // divided, saturated

    logic [63:0]    matrix_regs [vtpd_pkg::NUM_REGS];
    t_vertex_out    pending_vertices [$];
    int             mismatches;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             recv_hold_cycles;

    vertex_transform_perspective_divide DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Hard limit: far beyond the slowest correct run.
    initial begin
        #50_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Transform one vertex with the current coefficients: exact Q32.32 row sums,
    // round half up to Q16.16, then divide by the w sum unless it is zero.
    function automatic t_vertex_out transform_vertex(logic [31:0] vx, logic [31:0] vy,
                                                     logic [31:0] vz, logic [31:0] vw);
        logic signed [31:0] coord [4];
        logic signed [31:0] cf;
        logic signed [79:0] acc;
        logic signed [79:0] sums [4];
        logic [79:0]        num, den, quo;
        logic [31:0]        lane [3];
        logic               neg;
        t_vertex_out        res;
        coord[0] = vx;
        coord[1] = vy;
        coord[2] = vz;
        coord[3] = vw;
        res.saturated = 1'b0;
        for (int r = 0; r < 4; r++) begin
            acc = '0;
            for (int c = 0; c < 4; c++) begin
                cf  = matrix_regs[r * 2 + c / 2][(c % 2) * 32 +: 32];
                acc = acc + cf * coord[c];
            end
            sums[r] = (acc + 80'sd32768) >>> vtpd_pkg::FRAC_W;
        end
        res.divided = (sums[3] != 0);
        for (int i = 0; i < 3; i++) begin
            if (res.divided) begin
                // quotient on magnitudes, truncated toward zero
                neg = (sums[i] < 0) != (sums[3] < 0);
                num = (sums[i] < 0) ? -sums[i] : sums[i];
                den = (sums[3] < 0) ? -sums[3] : sums[3];
                if (num / den >= 80'h10000)
                    quo = 80'h1_0000_0000;
                else
                    quo = (num << vtpd_pkg::FRAC_W) / den;
                if (neg) begin
                    if (quo > 80'h8000_0000) begin
                        res.saturated = 1'b1;
                        quo = 80'h8000_0000;
                    end
                    quo = -quo;
                end else if (quo > 80'h7FFF_FFFF) begin
                    res.saturated = 1'b1;
                    quo = 80'h7FFF_FFFF;
                end
                lane[i] = quo[31:0];
            end else if (sums[i] > INT32_HI) begin
                res.saturated = 1'b1;
                lane[i] = 32'h7FFF_FFFF;
            end else if (sums[i] < INT32_LO) begin
                res.saturated = 1'b1;
                lane[i] = 32'h8000_0000;
            end else begin
                lane[i] = sums[i][31:0];
            end
        end
        res.x = lane[0];
        res.y = lane[1];
        res.z = lane[2];
        return res;
    endfunction

    // Receiver: stall at random, or hold off entirely while a hold count runs.
    always @(negedge i_clk) begin
        if (recv_hold_cycles > 0) begin
            m_axis_tready <= 1'b0;
            recv_hold_cycles <= recv_hold_cycles - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each accepted result word with the oldest pending vertex.
    always @(posedge i_clk) begin
        t_vertex_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_vertices.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h/%b", m_axis_tdata, m_axis_tuser);
            end else begin
                want = pending_vertices.pop_front();
                if (m_axis_tdata[31:0] !== want.x || m_axis_tdata[63:32] !== want.y ||
                    m_axis_tdata[95:64] !== want.z || m_axis_tuser[0] !== want.divided ||
                    m_axis_tuser[1] !== want.saturated) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp x=%h y=%h z=%h div=%b sat=%b",
                                 want.x, want.y, want.z, want.divided, want.saturated);
                        $display("          got x=%h y=%h z=%h div=%b sat=%b",
                                 m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
                                 m_axis_tuser[0], m_axis_tuser[1]);
                    end
                end
            end
        end
    end

    // Offer one vertex after a random gap; leave tvalid high on return.
    task automatic send_vertex(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                               logic [31:0] vw);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {vw, vz, vy, vx};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_vertices.push_back(transform_vertex(vx, vy, vz, vw));
        @(negedge i_clk);
    endtask

    // Stop offering, wait for every pending result, then let the pipe settle.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_vertices.size() != 0)
            @(negedge i_clk);
        repeat (PIPE_LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic write_coef_reg(t_reg_idx idx, logic [63:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        matrix_regs[idx] = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_small_coef();
        return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
    endfunction

    // Load all eight registers with one flavor of matrix.
    task automatic load_matrix(t_mat_kind kind);
        logic [63:0] value;
        for (int i = 0; i < vtpd_pkg::NUM_REGS; i++) begin
            case (kind)
                MAT_FULL:        value = {$urandom, $urandom};
                MAT_PERSPECTIVE: value = {rand_small_coef(), rand_small_coef()};
                MAT_MAX:         value = 64'h7FFF_FFFF_7FFF_FFFF;
                default:         value = 64'h8000_0000_8000_0000;
            endcase
            write_coef_reg(t_reg_idx'(i), value);
        end
    endtask

    // Typical vertex: modest coordinates, w mostly 1.0 or 0, some full-range noise.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
            default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
        endcase
    endfunction

    function automatic logic [31:0] rand_weight();
        case ($urandom_range(4))
            0:       return 32'h0;
            1:       return $urandom;
            default: return ONE_Q16;
        endcase
    endfunction

    task automatic test_directed();
        // identity matrix from reset: plain points, extremes and zero weight
        send_vertex(32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, ONE_Q16);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, ONE_Q16);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0);
        send_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0001);
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'hFFFF_FFFF);
        send_vertex(32'h0004_0000, 32'hFFFC_0000, 32'h0000_8000, 32'h0002_0000);
        send_vertex(32'h0, 32'h0, 32'h0, 32'h0);
        send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
        drain_results();
        // all-max coefficients: overflowing sums, divided
        load_matrix(MAT_MAX);
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vertex(32'h0001_0000, 32'h0, 32'h0, 32'h0);
        drain_results();
        // zero w row: undivided sums that saturate both ways
        write_coef_reg(ROW3_COLS01, 64'h0);
        write_coef_reg(ROW3_COLS23, 64'h0);
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vertex(32'h0000_0001, 32'h0, 32'h0, 32'h0);
        drain_results();
        // all-min coefficients
        load_matrix(MAT_MIN);
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_vertex(32'h7FFF_FFFF, 32'h0, 32'hFFFF_0000, ONE_Q16);
        send_vertex(32'hFFFF_FFFF, 32'h0000_0001, 32'h0, 32'h0);
        drain_results();
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, t_mat_kind kind, int count);
        load_matrix(kind);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++)
            send_vertex(rand_coord(), rand_coord(), rand_coord(), rand_weight());
        drain_results();
    endtask

    // Hold the output off long enough to fill the pipe and stall the input.
    task automatic test_backpressure();
        load_matrix(MAT_PERSPECTIVE);
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        recv_hold_cycles = 4 * PIPE_LATENCY + 40;
        for (int n = 0; n < 60; n++)
            send_vertex(rand_coord(), rand_coord(), rand_coord(), rand_weight());
        drain_results();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        m_axis_tready    = 1'b0;
        mismatches       = 0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        recv_hold_cycles = 0;
        for (int i = 0; i < vtpd_pkg::NUM_REGS; i++)
            matrix_regs[i] = vtpd_pkg::REG_RESET[i];
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random_phase(0, 0, MAT_PERSPECTIVE, 130);
        test_random_phase(71, 0, MAT_FULL, 110);
        test_random_phase(0, 71, MAT_PERSPECTIVE, 110);
        test_random_phase(30, 30, MAT_FULL, 110);
        test_backpressure();
        test_random_phase(30, 30, MAT_MAX, 30);

        if (mismatches == 0 && pending_vertices.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
